/* src/opp_pkg.sv */
// Shared types, constants and tables of the omnidirectional point projection block.
package opp_pkg;

    localparam int MAX_TERMS_DEFAULT = 16;
    localparam int ROOT_STEPS        = 32;
    localparam int CORDIC_STEPS      = 31;
    localparam int DIV_STEPS         = 32;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_E   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_TERMS = 3'd5;

    localparam logic OPC_PROJECT = 1'b0;
    localparam logic OPC_COEFF   = 1'b1;

    // Phases of the final multiply sequence.
    localparam logic [2:0] POST_U     = 3'd0;
    localparam logic [2:0] POST_V     = 3'd1;
    localparam logic [2:0] POST_ROW_C = 3'd2;
    localparam logic [2:0] POST_ROW_D = 3'd3;
    localparam logic [2:0] POST_COL   = 3'd4;

    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SQA, OP_SQB, OP_ADDN, OP_NORM, OP_SQRT,
        OP_CLOAD, OP_CPREP, OP_CORD, OP_TSTORE, OP_HZERO, OP_HINIT,
        OP_M1, OP_M2, OP_M3, OP_HACC, OP_DLOAD, OP_DIV, OP_DSTORE,
        OP_PST, OP_OUT, OP_AXIS
    } dp_op_t;

    typedef enum logic [2:0] {
        MS_RHO_THETA, MS_RHO_CA, MS_RHO_CB, MS_U_C, MS_V_D, MS_U_E
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t msel;
        logic [4:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic on_axis;
        logic c_zero;
        logic norm_done;
        logic prep_done;
    } dp_stat_t;

    // atan(2^-i) in Q2.30, rounded to nearest.
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/omnidirectional_point_projection.sv */
// Top level of the omnidirectional point projection block: controller, datapath and checks.
//
//   channel   signals                                    handshake
//   input     start, busy, opcode, point_*, coeff_*     word taken when start=1 and busy=0
//   result    done, pixel_col, pixel_row, on_axis,      word valid while done=1, one cycle
//             behind_camera
//   config    cfg_write, cfg_index, cfg_data            register written when cfg_write=1
//
// A coefficient word produces no result and is taken without leaving idle; busy stays low.
// A point on the optical axis returns its result straight from the first squaring state.
// Any other point keeps busy high through the norm, root, angle, polynomial, ratio and
// affine phases; leading zero bits of the squared norm are shifted out in pairs, the
// angle vector is pre-scaled one shift at a time, and a z of zero skips the angle phase.
// The result is presented as busy falls. The bit-serial square root, the 31-step angle
// rotation and the two 32-step divisions run in turn within this, with every fixed-point
// product passing through the M1, M2 and M3 states on one shared 32x32 multiplier.
// Reset is asynchronous and active low; the receiver cannot stall results.
module omnidirectional_point_projection #(
    parameter int MAX_TERMS = opp_pkg::MAX_TERMS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic signed [31:0]            point_x,
    input  logic signed [31:0]            point_y,
    input  logic signed [31:0]            point_z,
    input  logic [3:0]                    coeff_index,
    input  logic signed [47:0]            coeff_value,
    output logic                          done,
    output logic signed [31:0]            pixel_col,
    output logic signed [31:0]            pixel_row,
    output logic                          on_axis,
    output logic                          behind_camera,
    input  logic                          cfg_write,
    input  logic [opp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int TW = $clog2(MAX_TERMS + 1);
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    // The controller steps the datapath through norm, root, angle, polynomial,
    // ratio and affine phases; the datapath reports the few conditions that
    // decide loop exits and early returns.
    opp_pkg::dp_cmd_t  cmd;
    opp_pkg::dp_stat_t stat;
    logic [AW-1:0]     coeff_addr;
    logic [TW-1:0]     terms;

    opp_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (opcode),
        .terms      (terms),
        .stat       (stat),
        .cmd        (cmd),
        .coeff_addr (coeff_addr),
        .busy       (busy)
    );

    opp_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .coeff_addr    (coeff_addr),
        .stat          (stat),
        .terms         (terms),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .coeff_index   (coeff_index),
        .coeff_value   (coeff_value),
        .done          (done),
        .pixel_col     (pixel_col),
        .pixel_row     (pixel_row),
        .on_axis       (on_axis),
        .behind_camera (behind_camera)
    );

`ifndef NO_ASSERTIONS
    // A point word always makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == opp_pkg::OPC_PROJECT) |=> busy)
        else $error("point word did not start a computation");

    // A coefficient word leaves the block idle and produces no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == opp_pkg::OPC_COEFF) |=> !busy && !done)
        else $error("coefficient word produced activity");

    // Each result is a single-cycle strobe issued as the block returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
`endif

endmodule

/* src/opp_ctrl.sv */
// Sequencing state machine of the omnidirectional point projection block.
module opp_ctrl #(
    parameter int MAX_TERMS = opp_pkg::MAX_TERMS_DEFAULT,
    localparam int TW = $clog2(MAX_TERMS + 1),
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              opcode,
    input  logic [TW-1:0]     terms,
    input  opp_pkg::dp_stat_t stat,
    output opp_pkg::dp_cmd_t  cmd,
    output logic [AW-1:0]     coeff_addr,
    output logic              busy
);

    localparam int CW = (TW > 6) ? TW : 6;

    typedef enum logic [23:0] {
        S_IDLE   = 24'h000001,
        S_SQA    = 24'h000002,
        S_SQB    = 24'h000004,
        S_ADDN   = 24'h000008,
        S_NORM   = 24'h000010,
        S_SQRT   = 24'h000020,
        S_CLOAD  = 24'h000040,
        S_CPREP  = 24'h000080,
        S_CORD   = 24'h000100,
        S_TSTORE = 24'h000200,
        S_HSTART = 24'h000400,
        S_HINIT  = 24'h000800,
        S_HM1    = 24'h001000,
        S_HM2    = 24'h002000,
        S_HM3    = 24'h004000,
        S_HACC   = 24'h008000,
        S_DLOAD  = 24'h010000,
        S_DIV    = 24'h020000,
        S_DST    = 24'h040000,
        S_PM1    = 24'h080000,
        S_PM2    = 24'h100000,
        S_PM3    = 24'h200000,
        S_PST    = 24'h400000,
        S_OUT    = 24'h800000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    ph_reg, ph_next;
    logic          sel_reg, sel_next;

    function automatic opp_pkg::mul_sel_t post_sel(input logic [2:0] ph);
        opp_pkg::mul_sel_t s;
        case (ph)
            opp_pkg::POST_U:     s = opp_pkg::MS_RHO_CA;
            opp_pkg::POST_V:     s = opp_pkg::MS_RHO_CB;
            opp_pkg::POST_ROW_C: s = opp_pkg::MS_U_C;
            opp_pkg::POST_ROW_D: s = opp_pkg::MS_V_D;
            default:             s = opp_pkg::MS_U_E;
        endcase
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ph_reg    <= opp_pkg::POST_U;
            sel_reg   <= opp_pkg::SEL_A;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ph_reg    <= ph_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ph_next    = ph_reg;
        sel_next   = sel_reg;
        cmd.op     = opp_pkg::OP_NONE;
        cmd.msel   = opp_pkg::MS_RHO_THETA;
        cmd.step   = cnt_reg[4:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = opp_pkg::OP_LOAD;
                    if (opcode == opp_pkg::OPC_PROJECT)
                    begin
                        state_next = S_SQA;
                    end
                end
            end
            S_SQA:
            begin
                if (stat.on_axis)
                begin
                    cmd.op     = opp_pkg::OP_AXIS;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = opp_pkg::OP_SQA;
                    state_next = S_SQB;
                end
            end
            S_SQB:
            begin
                cmd.op     = opp_pkg::OP_SQB;
                state_next = S_ADDN;
            end
            S_ADDN:
            begin
                cmd.op     = opp_pkg::OP_ADDN;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.op = opp_pkg::OP_NORM;
                if (stat.norm_done)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op   = opp_pkg::OP_SQRT;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(opp_pkg::ROOT_STEPS - 1))
                begin
                    state_next = S_CLOAD;
                end
            end
            S_CLOAD:
            begin
                cmd.op     = opp_pkg::OP_CLOAD;
                state_next = stat.c_zero ? S_TSTORE : S_CPREP;
            end
            S_CPREP:
            begin
                cmd.op = opp_pkg::OP_CPREP;
                if (stat.prep_done)
                begin
                    cnt_next   = '0;
                    state_next = S_CORD;
                end
            end
            S_CORD:
            begin
                cmd.op   = opp_pkg::OP_CORD;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(opp_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = S_TSTORE;
                end
            end
            S_TSTORE:
            begin
                cmd.op     = opp_pkg::OP_TSTORE;
                cnt_next   = CW'(terms);
                state_next = S_HSTART;
            end
            S_HSTART:
            begin
                sel_next = opp_pkg::SEL_A;
                if (cnt_reg == '0)
                begin
                    cmd.op     = opp_pkg::OP_HZERO;
                    state_next = S_DLOAD;
                end
                else
                begin
                    state_next = S_HINIT;
                end
            end
            S_HINIT:
            begin
                cmd.op     = opp_pkg::OP_HINIT;
                cnt_next   = cnt_reg - CW'(1);
                state_next = (cnt_reg == CW'(1)) ? S_DLOAD : S_HM1;
            end
            S_HM1:
            begin
                cmd.op     = opp_pkg::OP_M1;
                cmd.msel   = opp_pkg::MS_RHO_THETA;
                state_next = S_HM2;
            end
            S_HM2:
            begin
                cmd.op     = opp_pkg::OP_M2;
                state_next = S_HM3;
            end
            S_HM3:
            begin
                cmd.op     = opp_pkg::OP_M3;
                state_next = S_HACC;
            end
            S_HACC:
            begin
                cmd.op     = opp_pkg::OP_HACC;
                cnt_next   = cnt_reg - CW'(1);
                state_next = (cnt_reg == CW'(1)) ? S_DLOAD : S_HM1;
            end
            S_DLOAD:
            begin
                cmd.op     = opp_pkg::OP_DLOAD;
                cmd.step   = {4'd0, sel_reg};
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = opp_pkg::OP_DIV;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(opp_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DST;
                end
            end
            S_DST:
            begin
                cmd.op   = opp_pkg::OP_DSTORE;
                cmd.step = {4'd0, sel_reg};
                if (sel_reg == opp_pkg::SEL_A)
                begin
                    sel_next   = opp_pkg::SEL_B;
                    state_next = S_DLOAD;
                end
                else
                begin
                    ph_next    = opp_pkg::POST_U;
                    state_next = S_PM1;
                end
            end
            S_PM1:
            begin
                cmd.op     = opp_pkg::OP_M1;
                cmd.msel   = post_sel(ph_reg);
                state_next = S_PM2;
            end
            S_PM2:
            begin
                cmd.op     = opp_pkg::OP_M2;
                state_next = S_PM3;
            end
            S_PM3:
            begin
                cmd.op     = opp_pkg::OP_M3;
                state_next = S_PST;
            end
            S_PST:
            begin
                cmd.op   = opp_pkg::OP_PST;
                cmd.step = {2'd0, ph_reg};
                if (ph_reg == opp_pkg::POST_COL)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ph_next    = ph_reg + 3'd1;
                    state_next = S_PM1;
                end
            end
            S_OUT:
            begin
                cmd.op     = opp_pkg::OP_OUT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign coeff_addr = AW'(cnt_reg - CW'(1));
    assign busy       = (state_reg != S_IDLE);

endmodule

/* src/opp_datapath.sv */
// Arithmetic datapath, configuration registers and coefficient memory of the projection block.
module opp_datapath #(
    parameter int MAX_TERMS = opp_pkg::MAX_TERMS_DEFAULT,
    localparam int TW = $clog2(MAX_TERMS + 1),
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  opp_pkg::dp_cmd_t                   cmd,
    input  logic [AW-1:0]                      coeff_addr,
    output opp_pkg::dp_stat_t                  stat,
    output logic [TW-1:0]                      terms,
    input  logic                               cfg_write,
    input  logic [opp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               opcode,
    input  logic signed [31:0]                 point_x,
    input  logic signed [31:0]                 point_y,
    input  logic signed [31:0]                 point_z,
    input  logic [3:0]                         coeff_index,
    input  logic signed [47:0]                 coeff_value,
    output logic                               done,
    output logic signed [31:0]                 pixel_col,
    output logic signed [31:0]                 pixel_row,
    output logic                               on_axis,
    output logic                               behind_camera
);

    localparam logic signed [52:0] LIM48_POS = 53'sd140737488355327;
    localparam logic signed [52:0] LIM48_NEG = -53'sd140737488355328;
    localparam logic signed [51:0] LIM32_POS = 52'sd2147483647;
    localparam logic signed [51:0] LIM32_NEG = -52'sd2147483648;

    // Configuration registers.
    logic signed [31:0] center_row_reg, center_col_reg;
    logic signed [31:0] affine_c_reg, affine_d_reg, affine_e_reg;
    logic [4:0]         poly_terms_reg;

    // Captured point.
    logic [31:0] ma_reg, mb_reg, mc_reg;
    logic        sa_reg, sb_reg, sc_reg, cz_reg, axis_reg, behind_reg;

    // Norm, root and angle.
    logic [63:0]        prod_reg, n2_reg, sres_reg, sbit_reg, pa_reg;
    logic [4:0]         h_reg;
    logic [31:0]        r_reg;
    logic signed [63:0] cx_reg, cy_reg;
    logic signed [32:0] ang_reg;
    logic signed [31:0] theta_reg;

    // Shared Q24.24 by Q2.30 multiply.
    logic [15:0]        lo_reg;
    logic [31:0]        my_reg;
    logic               neg_reg;
    logic signed [51:0] mres_reg;

    // Polynomial, ratios and sums.
    logic signed [47:0] rho_reg, rd_reg;
    logic [32:0]        drem_reg;
    logic [31:0]        dq_reg;
    logic               dsign_reg;
    logic signed [31:0] ca_reg, cb_reg;
    logic signed [51:0] u_reg, v_reg, row_reg, col_reg;
    logic               done_reg;

    logic signed [47:0] coeff_mem [MAX_TERMS];

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic signed [51:0] x_sel, x_mag;
    logic signed [31:0] y_sel;
    logic [31:0]        y_mag;
    logic [63:0]        sq_try, p_lo, p_mag, d_num;
    logic signed [63:0] xs, ys;
    logic signed [32:0] atan_ext;
    logic signed [52:0] hsum;
    logic [32:0]        d_try;
    logic               d_ge;
    logic signed [51:0] cr_q24, cc_q24;
    logic               coeff_we;

    function automatic logic signed [31:0] out_q16(input logic signed [51:0] v);
        logic signed [51:0] q;
        q = (v + 52'sd128) >>> 8;
        if (q > LIM32_POS)
        begin
            return 32'sh7FFFFFFF;
        end
        if (q < LIM32_NEG)
        begin
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    assign terms = (32'(poly_terms_reg) > MAX_TERMS) ? TW'(MAX_TERMS) : TW'(poly_terms_reg);

    assign stat.on_axis   = axis_reg;
    assign stat.c_zero    = cz_reg;
    assign stat.norm_done = (n2_reg[63:62] != 2'b00);
    assign stat.prep_done = (cy_reg[63:40] == '0);

    always_comb
    begin
        case (cmd.msel)
            opp_pkg::MS_RHO_THETA: begin x_sel = 52'(rho_reg); y_sel = theta_reg;    end
            opp_pkg::MS_RHO_CA:    begin x_sel = 52'(rho_reg); y_sel = ca_reg;       end
            opp_pkg::MS_RHO_CB:    begin x_sel = 52'(rho_reg); y_sel = cb_reg;       end
            opp_pkg::MS_U_C:       begin x_sel = u_reg;        y_sel = affine_c_reg; end
            opp_pkg::MS_V_D:       begin x_sel = v_reg;        y_sel = affine_d_reg; end
            default:               begin x_sel = u_reg;        y_sel = affine_e_reg; end
        endcase
    end

    assign x_mag = x_sel[51] ? -x_sel : x_sel;
    assign y_mag = y_sel[31] ? 32'(-y_sel) : 32'(y_sel);

    always_comb
    begin
        case (cmd.op)
            opp_pkg::OP_SQA: begin mul_a = ma_reg;         mul_b = ma_reg; end
            opp_pkg::OP_SQB: begin mul_a = mb_reg;         mul_b = mb_reg; end
            opp_pkg::OP_M1:  begin mul_a = x_mag[47:16];   mul_b = y_mag;  end
            default:         begin mul_a = {16'd0, lo_reg}; mul_b = my_reg; end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign sq_try   = sres_reg + sbit_reg;
    assign xs       = cx_reg >>> cmd.step;
    assign ys       = cy_reg >>> cmd.step;
    assign atan_ext = 33'({3'd0, opp_pkg::atan_q30(cmd.step)});
    assign p_lo     = ({50'd0, pa_reg[13:0]} << 16) + prod_reg + 64'd536870912;
    assign p_mag    = (pa_reg >> 14) + (p_lo >> 30);
    assign hsum     = 53'(mres_reg) + 53'(rd_reg);
    assign d_num    = ((64'(cmd.step[0] ? mb_reg : ma_reg) << h_reg) << 30)
                      + 64'(r_reg >> 1);
    assign d_try    = {drem_reg[31:0], dq_reg[31]};
    assign d_ge     = (d_try >= {1'b0, r_reg});
    assign cr_q24   = {{12{center_row_reg[31]}}, center_row_reg, 8'd0};
    assign cc_q24   = {{12{center_col_reg[31]}}, center_col_reg, 8'd0};
    assign coeff_we = (cmd.op == opp_pkg::OP_LOAD) && (opcode == opp_pkg::OPC_COEFF)
                      && (32'(coeff_index) < MAX_TERMS);

    always_ff @(posedge clk)
    begin
        if (coeff_we)
        begin
            coeff_mem[AW'(coeff_index)] <= coeff_value;
        end
        rd_reg <= coeff_mem[coeff_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_row_reg <= '0;
            center_col_reg <= '0;
            affine_c_reg   <= 32'sh40000000;
            affine_d_reg   <= '0;
            affine_e_reg   <= '0;
            poly_terms_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == opp_pkg::OP_OUT) || (cmd.op == opp_pkg::OP_AXIS);
            if (cfg_write)
            begin
                case (cfg_index)
                    opp_pkg::CFG_CENTER_ROW: center_row_reg <= cfg_data;
                    opp_pkg::CFG_CENTER_COL: center_col_reg <= cfg_data;
                    opp_pkg::CFG_AFFINE_C:   affine_c_reg   <= cfg_data;
                    opp_pkg::CFG_AFFINE_D:   affine_d_reg   <= cfg_data;
                    opp_pkg::CFG_AFFINE_E:   affine_e_reg   <= cfg_data;
                    opp_pkg::CFG_POLY_TERMS: poly_terms_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            opp_pkg::OP_LOAD:
            begin
                ma_reg     <= point_y[31] ? 32'(-point_y) : 32'(point_y);
                mb_reg     <= point_x[31] ? 32'(-point_x) : 32'(point_x);
                mc_reg     <= point_z[31] ? 32'(-point_z) : 32'(point_z);
                sa_reg     <= point_y[31];
                sb_reg     <= point_x[31];
                sc_reg     <= !point_z[31] && (point_z != '0);
                cz_reg     <= (point_z == '0);
                behind_reg <= !point_z[31] && (point_z != '0);
                axis_reg   <= (point_x == '0) && (point_y == '0);
            end
            opp_pkg::OP_SQA:
            begin
                prod_reg <= mul_p;
            end
            opp_pkg::OP_SQB:
            begin
                n2_reg   <= prod_reg;
                prod_reg <= mul_p;
            end
            opp_pkg::OP_ADDN:
            begin
                n2_reg   <= n2_reg + prod_reg;
                h_reg    <= '0;
                sres_reg <= '0;
                sbit_reg <= 64'h4000_0000_0000_0000;
            end
            opp_pkg::OP_NORM:
            begin
                if (n2_reg[63:62] == 2'b00)
                begin
                    n2_reg <= n2_reg << 2;
                    h_reg  <= h_reg + 5'd1;
                end
            end
            opp_pkg::OP_SQRT:
            begin
                if (n2_reg >= sq_try)
                begin
                    n2_reg   <= n2_reg - sq_try;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            opp_pkg::OP_CLOAD:
            begin
                r_reg   <= sres_reg[31:0];
                cx_reg  <= {32'd0, sres_reg[31:0]};
                cy_reg  <= 64'(mc_reg) << h_reg;
                ang_reg <= '0;
            end
            opp_pkg::OP_CPREP:
            begin
                if (cy_reg[63:40] != '0)
                begin
                    cx_reg <= cx_reg >>> 1;
                    cy_reg <= cy_reg >>> 1;
                end
            end
            opp_pkg::OP_CORD:
            begin
                if (!cy_reg[63])
                begin
                    cx_reg  <= cx_reg + ys;
                    cy_reg  <= cy_reg - xs;
                    ang_reg <= ang_reg + atan_ext;
                end
                else
                begin
                    cx_reg  <= cx_reg - ys;
                    cy_reg  <= cy_reg + xs;
                    ang_reg <= ang_reg - atan_ext;
                end
            end
            opp_pkg::OP_TSTORE:
            begin
                theta_reg <= sc_reg ? 32'(-ang_reg) : 32'(ang_reg);
            end
            opp_pkg::OP_HZERO:
            begin
                rho_reg <= '0;
            end
            opp_pkg::OP_HINIT:
            begin
                rho_reg <= rd_reg;
            end
            opp_pkg::OP_M1:
            begin
                prod_reg <= mul_p;
                lo_reg   <= x_mag[15:0];
                my_reg   <= y_mag;
                neg_reg  <= x_sel[51] ^ y_sel[31];
            end
            opp_pkg::OP_M2:
            begin
                pa_reg   <= prod_reg;
                prod_reg <= mul_p;
            end
            opp_pkg::OP_M3:
            begin
                mres_reg <= neg_reg ? 52'(64'd0 - p_mag) : 52'(p_mag);
            end
            opp_pkg::OP_HACC:
            begin
                if (hsum > LIM48_POS)
                begin
                    rho_reg <= 48'(LIM48_POS);
                end
                else if (hsum < LIM48_NEG)
                begin
                    rho_reg <= 48'(LIM48_NEG);
                end
                else
                begin
                    rho_reg <= hsum[47:0];
                end
            end
            opp_pkg::OP_DLOAD:
            begin
                drem_reg  <= {1'b0, d_num[63:32]};
                dq_reg    <= d_num[31:0];
                dsign_reg <= cmd.step[0] ? sb_reg : sa_reg;
            end
            opp_pkg::OP_DIV:
            begin
                drem_reg <= d_ge ? (d_try - {1'b0, r_reg}) : d_try;
                dq_reg   <= {dq_reg[30:0], d_ge};
            end
            opp_pkg::OP_DSTORE:
            begin
                if (cmd.step[0] == opp_pkg::SEL_B)
                begin
                    cb_reg <= dsign_reg ? 32'(-dq_reg) : 32'(dq_reg);
                end
                else
                begin
                    ca_reg <= dsign_reg ? 32'(-dq_reg) : 32'(dq_reg);
                end
            end
            opp_pkg::OP_PST:
            begin
                case (cmd.step[2:0])
                    opp_pkg::POST_U:     u_reg   <= mres_reg;
                    opp_pkg::POST_V:     v_reg   <= mres_reg;
                    opp_pkg::POST_ROW_C: row_reg <= mres_reg + cr_q24;
                    opp_pkg::POST_ROW_D: row_reg <= row_reg + mres_reg;
                    default:             col_reg <= mres_reg + v_reg + cc_q24;
                endcase
            end
            opp_pkg::OP_OUT:
            begin
                pixel_col     <= out_q16(col_reg);
                pixel_row     <= out_q16(row_reg);
                on_axis       <= 1'b0;
                behind_camera <= behind_reg;
            end
            opp_pkg::OP_AXIS:
            begin
                pixel_col     <= center_col_reg;
                pixel_row     <= center_row_reg;
                on_axis       <= 1'b1;
                behind_camera <= behind_reg;
            end
            default: ;
        endcase
    end

    assign done = done_reg;

endmodule

/* tb/omnidirectional_point_projection_tb.sv */
// Self-checking testbench for the omnidirectional point projection block.
module omnidirectional_point_projection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import opp_pkg::*;

    // Cycles allowed after the last result before the block is treated as idle.
    localparam int SETTLE_CYCLES = 400;
    // Cycles with no handshake of any kind before the run is abandoned.
    localparam int STALL_LIMIT = 20000;
    localparam int COEF_SLOTS = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
    localparam longint LIM48_HI = 64'sd140737488355327;
    localparam longint LIM48_LO = -64'sd140737488355328;

    // One input word as the sender presents it.
    typedef struct {
        logic               op;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [3:0]         idx;
        logic signed [47:0] val;
    } word_t;

    // One projected pixel as the block reports it.
    typedef struct {
        logic signed [31:0] col;
        logic signed [31:0] row;
        logic               axis;
        logic               behind;
    } pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 opcode = OPC_PROJECT;
    logic signed [31:0]   point_x = '0;
    logic signed [31:0]   point_y = '0;
    logic signed [31:0]   point_z = '0;
    logic [3:0]           coeff_index = '0;
    logic signed [47:0]   coeff_value = '0;
    logic                 done;
    logic signed [31:0]   pixel_col;
    logic signed [31:0]   pixel_row;
    logic                 on_axis;
    logic                 behind_camera;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    omnidirectional_point_projection i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .coeff_index   (coeff_index),
        .coeff_value   (coeff_value),
        .done          (done),
        .pixel_col     (pixel_col),
        .pixel_row     (pixel_row),
        .on_axis       (on_axis),
        .behind_camera (behind_camera),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Shadow copy of the block's registers and coefficient table.
    logic [31:0]  sh_center_row = '0;
    logic [31:0]  sh_center_col = '0;
    logic [31:0]  sh_affine_c = 32'h4000_0000;
    logic [31:0]  sh_affine_d = '0;
    logic [31:0]  sh_affine_e = '0;
    logic [4:0]   sh_terms = '0;
    longint       sh_coef [COEF_SLOTS];

    // atan(2^-i) in Q2.30, rounded to nearest.
    longint arc_table [31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1
    };

    word_t  pending_words [$];
    pixel_t pixels_due [$];
    int     words_pushed = 0;
    int     words_taken = 0;
    int     mismatches = 0;
    int     gap_max = 16;

    function automatic bit [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Q24.24 times Q2.30 on magnitudes, rounded half away from zero to Q24.24.
    function automatic longint mul_q30(longint x, longint y);
        bit        neg;
        bit [63:0] mx;
        bit [63:0] my;
        bit [63:0] pa;
        bit [63:0] pb;
        bit [63:0] p;
        neg = (x < 0) != (y < 0);
        mx = magnitude(x);
        my = magnitude(y);
        pa = (mx >> 16) * my;
        pb = (mx & 64'hFFFF) * my + (64'd1 << 29);
        p = (pa >> 14) + ((((pa & 64'h3FFF) << 16) + pb) >> 30);
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clamp48(longint v);
        if (v > LIM48_HI)
            return LIM48_HI;
        if (v < LIM48_LO)
            return LIM48_LO;
        return v;
    endfunction

    function automatic bit [63:0] floor_sqrt(bit [63:0] n);
        bit [63:0] res;
        bit [63:0] bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt != 0)
        begin
            if (n >= res + bt)
            begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint direction(longint p, int h, bit [63:0] r);
        bit [63:0] num;
        longint    q;
        num = ((magnitude(p) << h) << 30) + (r >> 1);
        q = longint'(num / r);
        return (p < 0) ? -q : q;
    endfunction

    function automatic logic [31:0] to_pixel(longint q24);
        longint q;
        q = (q24 + 128) >>> 8;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    // Applies one accepted word to the shadow state; returns 1 with the
    // expected pixel when the word is a projection.
    function automatic bit project_word(word_t w, output pixel_t px);
        longint    a, b, c, theta, rho, ca, cb, u, v, row, col, x, y, ang, xs, ys;
        bit [63:0] n2, r, mc, t;
        int        h, k, bl, terms;
        px = '{default: '0};
        if (w.op == OPC_COEFF)
        begin
            sh_coef[w.idx] = longint'(w.val);
            return 1'b0;
        end
        a = longint'(w.py);
        b = longint'(w.px);
        c = -longint'(w.pz);
        px.behind = (w.pz > 0);
        if (a == 0 && b == 0)
        begin
            px.col = sh_center_col;
            px.row = sh_center_row;
            px.axis = 1'b1;
            return 1'b1;
        end
        n2 = magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b);
        h = 0;
        while (n2[63:62] == 2'b00)
        begin
            n2 <<= 2;
            h++;
        end
        r = floor_sqrt(n2);

        // Angle by CORDIC vectoring, with both legs pre-scaled to 40 bits.
        theta = 0;
        mc = magnitude(c);
        if (mc != 0)
        begin
            bl = 0;
            t = mc;
            while (t != 0)
            begin
                bl++;
                t >>= 1;
            end
            k = (bl + h > 40) ? bl + h - 40 : 0;
            x = longint'(r >> k);
            y = (h >= k) ? longint'(mc << (h - k)) : longint'(mc >> (k - h));
            ang = 0;
            for (int i = 0; i < 31; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys;
                    y -= xs;
                    ang += arc_table[i];
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    ang -= arc_table[i];
                end
            end
            theta = (c < 0) ? -ang : ang;
        end

        terms = (sh_terms > COEF_SLOTS) ? COEF_SLOTS : int'(sh_terms);
        rho = 0;
        if (terms > 0)
        begin
            rho = sh_coef[terms-1];
            for (int i = terms - 1; i > 0; i--)
                rho = clamp48(mul_q30(rho, theta) + sh_coef[i-1]);
        end
        ca = direction(a, h, r);
        cb = direction(b, h, r);
        u = mul_q30(rho, ca);
        v = mul_q30(rho, cb);
        row = mul_q30(u, longint'($signed(sh_affine_c)))
            + mul_q30(v, longint'($signed(sh_affine_d)))
            + longint'($signed(sh_center_row)) * 256;
        col = mul_q30(u, longint'($signed(sh_affine_e))) + v
            + longint'($signed(sh_center_col)) * 256;
        px.col = to_pixel(col);
        px.row = to_pixel(row);
        return 1'b1;
    endfunction

    // Driver: presents queued words on start, with a random gap before each.
    int    gap_left = 0;
    word_t cur;
    always @(posedge clk)
    begin
        pixel_t px;
        logic   next_start;
        next_start = start;
        if (start && !busy)
        begin
            words_taken++;
            if (project_word(cur, px))
                pixels_due.push_back(px);
            next_start = 1'b0;
        end
        if (rst_n && !next_start)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_words.size() > 0)
            begin
                cur = pending_words.pop_front();
                opcode <= cur.op;
                point_x <= cur.px;
                point_y <= cur.py;
                point_z <= cur.pz;
                coeff_index <= cur.idx;
                coeff_value <= cur.val;
                next_start = 1'b1;
                gap_left = $urandom_range(0, gap_max);
            end
        end
        start <= next_start;
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && done)
        begin
            if (pixels_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result col=%h row=%h axis=%b behind=%b",
                             pixel_col, pixel_row, on_axis, behind_camera);
            end
            else
            begin
                want = pixels_due.pop_front();
                if (pixel_col !== want.col || pixel_row !== want.row
                    || on_axis !== want.axis || behind_camera !== want.behind)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected col=%h row=%h axis=%b behind=%b, %s",
                                 want.col, want.row, want.axis, want.behind,
                                 $sformatf("got col=%h row=%h axis=%b behind=%b",
                                           pixel_col, pixel_row, on_axis,
                                           behind_camera));
                end
            end
        end
    end

    // Watchdog: any handshake restarts the count.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("omnidirectional_point_projection verification failed");
            $finish;
        end
    end

    task automatic push_word(word_t w);
        pending_words.push_back(w);
        words_pushed++;
    endtask

    task automatic push_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        push_word('{OPC_PROJECT, x, y, z, 4'd0, 48'sd0});
    endtask

    task automatic push_coef(logic [3:0] idx, logic signed [47:0] val);
        push_word('{OPC_COEFF, $urandom, $urandom, $urandom, idx, val});
    endtask

    // Waits until every word is taken and every result has arrived. When
    // settle is set, it then waits out the settle time with the block idle.
    task automatic wait_drained(bit settle);
        while (!(words_taken == words_pushed && pixels_due.size() == 0 && !busy))
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_CENTER_ROW: sh_center_row = data;
            CFG_CENTER_COL: sh_center_col = data;
            CFG_AFFINE_C:   sh_affine_c = data;
            CFG_AFFINE_D:   sh_affine_d = data;
            CFG_AFFINE_E:   sh_affine_e = data;
            CFG_POLY_TERMS: sh_terms = data[4:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic signed [47:0] soft_coef();
        logic signed [47:0] v;
        v = 48'({$urandom, $urandom});
        return v >>> $urandom_range(12, 26);
    endfunction

    function automatic logic signed [31:0] any_coord();
        logic signed [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: return v;
            1: return v >>> $urandom_range(0, 31);
            2: return v >>> 8;
            default: return v >>> 14;
        endcase
    endfunction

    // Mostly ordinary points in front of the camera, with axis points,
    // behind-camera points and coefficient rewrites mixed in.
    function automatic word_t random_word();
        word_t w;
        int    pick;
        pick = $urandom_range(0, 19);
        w = '{OPC_PROJECT, any_coord(), any_coord(), any_coord(), 4'd0, 48'sd0};
        if (pick < 2)
        begin
            w.op = OPC_COEFF;
            w.idx = 4'($urandom_range(0, 15));
            w.val = (pick == 0) ? 48'({$urandom, $urandom}) : soft_coef();
        end
        else if (pick == 2)
        begin
            w.px = '0;
            w.py = '0;
        end
        else if (pick < 14 && w.pz > 0)
            w.pz = -w.pz;
        return w;
    endfunction

    initial
    begin
        logic [31:0] regs [6];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under reset settings: table extremes, then points at
        // the field extremes, on the axis and behind the camera.
        push_coef(4'd0, 48'sh8000_0000_0000);
        push_coef(4'd15, 48'sh7FFF_FFFF_FFFF);
        for (int i = 1; i < 15; i++)
            push_coef(4'(i), soft_coef());
        push_point(32'sd0, 32'sd0, -32'sd65536);
        push_point(32'sd0, 32'sd0, 32'sd65536);
        push_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        push_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_point(32'sh8000_0000, 32'sh8000_0000, 32'sd0);
        push_point(32'sd1, 32'sd0, -32'sd1);
        push_point(32'sd0, -32'sd1, 32'sh7FFF_FFFF);
        push_point(32'sd300000, -32'sd200000, -32'sd500000);
        wait_drained(1'b1);

        // Pause after every word until its result has come back.
        gap_max = 0;
        for (int i = 0; i < 30; i++)
        begin
            push_word(random_word());
            wait_drained(1'b0);
        end
        wait_drained(1'b1);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: regs = '{32'h0200_0000, 32'h0280_0000, 32'h4000_0000,
                           32'h0010_0000, 32'hFFF0_0000, 32'd5};
                1: regs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'd31};
                2: regs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'd16};
                3: regs = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0};
                4: regs = '{32'h0, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 32'd1};
                default: regs = '{$urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom_range(0, 31)};
            endcase
            write_reg(CFG_CENTER_ROW, regs[0]);
            write_reg(CFG_CENTER_COL, regs[1]);
            write_reg(CFG_AFFINE_C, regs[2]);
            write_reg(CFG_AFFINE_D, regs[3]);
            write_reg(CFG_AFFINE_E, regs[4]);
            write_reg(CFG_POLY_TERMS, regs[5]);
            write_reg(CFG_UNUSED, $urandom);
            end_writes();

            // Odd phases send back to back, even ones with random gaps.
            gap_max = ph[0] ? 0 : 16;
            for (int i = 0; i < 16; i++)
                push_coef(4'(i), soft_coef());
            for (int i = 0; i < 180; i++)
                push_word(random_word());
            wait_drained(1'b1);
        end

        if (mismatches == 0 && pixels_due.size() == 0)
            $display("omnidirectional_point_projection verification clean");
        else
            $display("omnidirectional_point_projection verification failed");
        $finish;
    end

endmodule

/* omnidirectional_point_projection.f */
src/opp_pkg.sv
src/opp_ctrl.sv
src/opp_datapath.sv
src/omnidirectional_point_projection.sv
tb/omnidirectional_point_projection_tb.sv
